/* rtl/pir_pkg.sv */
// ----------------------------------------------------------------------------
// pir_pkg
// Types, codes and helpers shared by the pulse interval reporter modules.
// ----------------------------------------------------------------------------
package pir_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int REPORT_WIDTH = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic       FUNC_TICK   = 1'b0;
    localparam logic       FUNC_CMD    = 1'b1;

    localparam logic [7:0] CMD_START   = 8'd106;
    localparam logic [7:0] CMD_STOP    = 8'd182;
    localparam logic [7:0] REPLY_START = 8'd107;
    localparam logic [7:0] REPLY_STOP  = 8'd183;
    localparam logic [7:0] MARK_READY  = 8'd198;

    localparam logic [1:0] IDX_MARK    = 2'd0;
    localparam logic [1:0] IDX_LOW     = 2'd1;
    localparam logic [1:0] IDX_HIGH    = 2'd2;

    typedef struct packed {
        logic       func;
        logic       pin_level;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_START,
        JOB_STOP,
        JOB_REPORT
    } t_job_kind;

    typedef struct packed {
        t_job_kind                 kind;
        logic [REPORT_WIDTH-1:0]   value;
    } t_job;

    function automatic logic [REPORT_WIDTH-1:0] to_report(
        input logic [COUNT_WIDTH-1:0] sum
    );
        logic [COUNT_WIDTH+REPORT_WIDTH-1:0] wide;
        wide = (COUNT_WIDTH + REPORT_WIDTH)'(sum);
        return wide[REPORT_WIDTH-1:0];
    endfunction

endpackage

/* rtl/pir_queue.sv */
// ----------------------------------------------------------------------------
// pir_queue
// Short job queue between the classifying front and the byte-emitting back.
// ----------------------------------------------------------------------------
module pir_queue
    import pir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_push_job,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_head_valid,
    output t_job  o_head_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("job popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* rtl/pir_front.sv */
// ----------------------------------------------------------------------------
// pir_front
// Accepts ticks and command bytes, tracks pulse phases and issues jobs.
// ----------------------------------------------------------------------------
module pir_front
    import pir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_queue_full,
    output logic      o_push,
    output t_job      o_push_job
);

    logic                   r_on,   n_on;
    logic                   r_high, n_high;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [COUNT_WIDTH-1:0] r_low,  n_low;
    logic [COUNT_WIDTH-1:0] r_half, n_half;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [COUNT_WIDTH-1:0] half_new;
    logic [COUNT_WIDTH-1:0] sum;
    logic                   accept;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign tick_inc   = r_tick + COUNT_WIDTH'(1);
    assign half_new   = tick_inc >> 1;
    assign sum        = r_half + half_new + r_low;

    always_comb begin
        n_on             = r_on;
        n_high           = r_high;
        n_tick           = r_tick;
        n_low            = r_low;
        n_half           = r_half;
        o_push           = 1'b0;
        o_push_job.kind  = JOB_START;
        o_push_job.value = to_report(sum);
        if (accept) begin
            if (i_in_data.func == FUNC_CMD) begin
                if (i_in_data.rx_byte == CMD_START) begin
                    n_on            = 1'b1;
                    o_push          = 1'b1;
                    o_push_job.kind = JOB_START;
                end else if (i_in_data.rx_byte == CMD_STOP) begin
                    n_on            = 1'b0;
                    n_tick          = '0;
                    n_low           = '0;
                    n_half          = '0;
                    o_push          = 1'b1;
                    o_push_job.kind = JOB_STOP;
                end
            end else begin
                n_tick = tick_inc;
                if (r_on) begin
                    if (i_in_data.pin_level && !r_high) begin
                        n_high = 1'b1;
                        n_low  = tick_inc;
                        n_tick = '0;
                    end else if (!i_in_data.pin_level && r_high) begin
                        n_high = 1'b0;
                        n_half = half_new;
                        n_tick = '0;
                        if (r_half != '0 && r_low > COUNT_WIDTH'(1)) begin
                            o_push          = 1'b1;
                            o_push_job.kind = JOB_REPORT;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on   <= 1'b0;
            r_high <= 1'b0;
            r_tick <= '0;
            r_low  <= '0;
            r_half <= '0;
        end else begin
            r_on   <= n_on;
            r_high <= n_high;
            r_tick <= n_tick;
            r_low  <= n_low;
            r_half <= n_half;
        end
    end

endmodule

/* rtl/pir_back.sv */
// ----------------------------------------------------------------------------
// pir_back
// Takes jobs from the queue and sends their bytes through an output register.
// ----------------------------------------------------------------------------
module pir_back
    import pir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    logic      [1:0] r_idx, n_idx;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out;
    t_out_item       byte_sel;
    logic            slot_free;
    logic            load;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign load        = slot_free && i_head_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        byte_sel.tx_byte = REPLY_START;
        byte_sel.last    = 1'b1;
        unique case (i_head_job.kind)
            JOB_START: begin
                byte_sel.tx_byte = REPLY_START;
            end
            JOB_STOP: begin
                byte_sel.tx_byte = REPLY_STOP;
            end
            JOB_REPORT: begin
                unique case (r_idx)
                    IDX_MARK: begin
                        byte_sel.tx_byte = MARK_READY;
                        byte_sel.last    = 1'b0;
                    end
                    IDX_LOW: begin
                        byte_sel.tx_byte = i_head_job.value[7:0];
                        byte_sel.last    = 1'b0;
                    end
                    default: begin
                        byte_sel.tx_byte = i_head_job.value[15:8];
                    end
                endcase
            end
            default: begin
                byte_sel.tx_byte = REPLY_START;
            end
        endcase

        o_pop       = load && byte_sel.last;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = byte_sel.last ? IDX_MARK : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_MARK;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= byte_sel;
        end
    end

    a_idx_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != IDX_MARK) |-> (i_head_valid && i_head_job.kind == JOB_REPORT))
        else $error("byte index advanced outside a report job");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("byte index out of range");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_out_valid && o_out_data.last))
        else $error("job retired without its final byte");

endmodule

/* rtl/pulse_interval_reporter_core.sv */
// ----------------------------------------------------------------------------
// pulse_interval_reporter_core
// Pulse period reporter: classifying front, job queue and byte-sending back.
// ----------------------------------------------------------------------------
// The front takes one item per cycle while the two-entry job queue has room;
// the back sends one byte per cycle, while the receiver does not stall, through
// a registered output: a command reply is a single byte and a falling-edge
// report three (ready marker, low byte, high byte). Items that give no bytes
// are handled at the front only. Sustained throughput is thus set by the
// number of bytes the back sends for each item.
module pulse_interval_reporter_core
    import pir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    logic push;
    t_job push_job;
    logic queue_full;
    logic pop;
    logic head_valid;
    t_job head_job;

    pir_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_job   (push_job)
    );

    pir_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_job   (head_job)
    );

    pir_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_job   (head_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

/* verif/pir_interval_checker.sv */
// ----------------------------------------------------------------------------
// pir_interval_checker
// Watches both channels of the pulse interval reporter, predicts the
// transmit bytes for every input transfer and compares each output transfer
// in order against the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pir_interval_checker
    import pir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_predicted
);

    logic                   monitoring_on;
    logic                   level_high;
    logic [COUNT_WIDTH-1:0] tick_count;
    logic [COUNT_WIDTH-1:0] low_len;
    logic [COUNT_WIDTH-1:0] half_high;
    t_out_item              expected_bytes[$];
    t_out_item              want;
    int                     fail_count = 0;
    int                     predicted  = 0;

    task automatic clear_counts();
        tick_count = '0;
        low_len    = '0;
        half_high  = '0;
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic is_last);
        t_out_item e;
        e.tx_byte = value;
        e.last    = is_last;
        expected_bytes.push_back(e);
        predicted++;
    endtask

    task automatic advance_interval(input t_in_item item);
        logic [COUNT_WIDTH-1:0] old_half;
        logic [COUNT_WIDTH-1:0] sum;
        logic [31:0]            wide;
        if (item.func == FUNC_CMD) begin
            if (item.rx_byte == CMD_START) begin
                monitoring_on = 1'b1;
                queue_byte(REPLY_START, 1'b1);
            end else if (item.rx_byte == CMD_STOP) begin
                monitoring_on = 1'b0;
                clear_counts();
                queue_byte(REPLY_STOP, 1'b1);
            end
        end else begin
            tick_count = tick_count + 1'b1;
            if (monitoring_on) begin
                if (item.pin_level && !level_high) begin
                    level_high = 1'b1;
                    low_len    = tick_count;
                    tick_count = '0;
                end else if (!item.pin_level && level_high) begin
                    old_half   = half_high;
                    level_high = 1'b0;
                    half_high  = tick_count >> 1;
                    if (old_half != '0 && low_len > 1) begin
                        sum  = old_half + half_high + low_len;
                        wide = 32'(sum);
                        queue_byte(MARK_READY, 1'b0);
                        queue_byte(wide[7:0], 1'b0);
                        queue_byte(wide[15:8], 1'b1);
                    end
                    tick_count = '0;
                end
            end
        end
    endtask

    task automatic note_fault(input string what, input bit has_want,
                              input t_out_item exp_item, input t_out_item got);
        fail_count++;
        if (fail_count <= 10) begin
            if (has_want)
                $display("%0t: %s: expected byte %0d last %0d, got byte %0d last %0d",
                         $time, what, exp_item.tx_byte, exp_item.last,
                         got.tx_byte, got.last);
            else
                $display("%0t: %s: got byte %0d last %0d", $time, what,
                         got.tx_byte, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            monitoring_on = 1'b0;
            level_high    = 1'b0;
            clear_counts();
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    note_fault("unexpected output transfer", 1'b0, '0, i_out_data);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.tx_byte !== i_out_data.tx_byte || want.last !== i_out_data.last)
                        note_fault("output mismatch", 1'b1, want, i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall)
                advance_interval(i_in_data);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_bytes.size();
        o_predicted  <= predicted;
    end

endmodule

/* verif/tb_pulse_interval_reporter_core.sv */
// ----------------------------------------------------------------------------
// tb_pulse_interval_reporter_core
// Drives commands and pin sample ticks into the pulse interval reporter:
// directed edge cases, a receiver hold-off and random pulse trains with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pulse_interval_reporter_core;
    import pir_pkg::*;

    localparam int LIMIT        = 20_000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_ITEMS      = 160;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;
    int predicted;

    int  cycles       = 0;
    int  transfers    = 0;
    int  useful       = 0;
    int  bursts       = 0;
    int  tx_idle_pct  = 31;
    int  rx_idle_pct  = 31;
    bit  hold_req     = 1'b0;
    bit  hold_done    = 1'b0;
    int  hold_left    = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pulse_interval_reporter_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    pir_interval_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_predicted  (predicted)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("pulse_interval_reporter_core test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic t_in_item make_item(input logic func, input logic pin,
                                           input logic [7:0] rx_byte);
        t_in_item item;
        item.func      = func;
        item.pin_level = pin;
        item.rx_byte   = rx_byte;
        return item;
    endfunction

    task automatic push_item(input t_in_item item);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        transfers++;
        if (item.func == FUNC_TICK || item.rx_byte == CMD_START || item.rx_byte == CMD_STOP)
            useful++;
    endtask

    task automatic push_cmd(input logic [7:0] code);
        push_item(make_item(FUNC_CMD, 1'($urandom_range(1)), code));
    endtask

    task automatic send_ticks(input logic pin, input int count);
        for (int k = 0; k < count; k++)
            push_item(make_item(FUNC_TICK, pin, 8'($urandom_range(255))));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_noise();
        int       pick;
        t_in_item item;
        for (int k = 0; k < 3; k++) begin
            pick = $urandom_range(99);
            item = make_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                             8'($urandom_range(255)));
            if (item.func == FUNC_CMD && pick < 20)
                item.rx_byte = CMD_START;
            else if (item.func == FUNC_CMD && pick < 28)
                item.rx_byte = CMD_STOP;
            push_item(item);
        end
    endtask

    function automatic int phase_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 1;
        return $urandom_range(12, 2);
    endfunction

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored bytes, repeated start, short and minimal phases
        push_item(make_item(FUNC_TICK, 1'b1, 8'hFF));
        push_item(make_item(FUNC_CMD, 1'b1, 8'h00));
        push_item(make_item(FUNC_CMD, 1'b0, 8'hFF));
        push_cmd(REPLY_START);
        push_cmd(CMD_START);
        push_cmd(CMD_START);
        send_ticks(1'b1, 3);
        send_ticks(1'b0, 3);
        send_ticks(1'b1, 4);
        send_ticks(1'b0, 1);
        send_ticks(1'b1, 2);
        send_ticks(1'b0, 1);
        push_cmd(CMD_STOP);
        push_cmd(REPLY_STOP);
        push_cmd(8'd181);
        wait_drained();

        // hold the receiver off while replies keep coming
        hold_req <= 1'b1;
        for (int k = 0; k < 10; k++)
            push_cmd(CMD_START);
        wait_drained();

        while (transfers < N_ITEMS) begin
            bursts++;
            if (bursts >= 3 && bursts < 7) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end else begin
                tx_idle_pct <= 31;
                rx_idle_pct <= 31;
            end
            if ($urandom_range(99) < 15) begin
                send_noise();
            end else begin
                if ($urandom_range(3) == 0)
                    push_cmd(CMD_START);
                send_ticks(1'b0, phase_len());
                send_ticks(1'b1, phase_len());
            end
        end
        send_ticks(1'b0, 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d input transfers (%0d ticks or commands), %0d bytes checked.",
                 transfers, useful, predicted);
        $display("Summary: start/stop commands, short and minimal phases, noise, stalls, hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("pulse_interval_reporter_core test passed");
        else
            $display("pulse_interval_reporter_core test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/pir_pkg.sv
rtl/pir_queue.sv
rtl/pir_front.sv
rtl/pir_back.sv
rtl/pulse_interval_reporter_core.sv
verif/pir_interval_checker.sv
verif/tb_pulse_interval_reporter_core.sv
